### rtl/windowed_peak_strength_core_macros.svh
`ifndef WINDOWED_PEAK_STRENGTH_CORE_MACROS_SVH
`define WINDOWED_PEAK_STRENGTH_CORE_MACROS_SVH

// same-cycle implication
`define WPS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define WPS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### rtl/wps_pkg.sv
`timescale 1ns / 1ps

package wps_pkg;

   localparam int CFG_W        = 5;
   localparam int SAMPLE_W     = 16;
   localparam int STRENGTH_W   = 17;
   localparam int INDEX_W      = 16;
   localparam int FILL_W       = 6;
   localparam int FILL_CAP     = 63;
   localparam int WINDOW_RESET = 8;
   localparam int DEN_W        = CFG_W + 1;
   localparam int RSP_DATA_W   = 40;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

### rtl/wps_ram.sv
`timescale 1ns / 1ps

module wps_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/wps_div.sv
`timescale 1ns / 1ps

module wps_div import wps_pkg::*; #(
   parameter int NUM_W = 22,
   parameter int QUO_W = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [NUM_W-1:0]     dividend,
   input  logic [DEN_W-1:0]     divisor,
   output div_status_type       status,
   output logic [QUO_W-1:0]     quotient
);

   localparam int DSH_W  = DEN_W + QUO_W - 1;
   localparam int CW     = (NUM_W > DSH_W) ? NUM_W : DSH_W;
   localparam int STEP_W = $clog2(QUO_W + 1);

   logic [CW-1:0]     rem_ff, rem_in;
   logic [CW-1:0]     dsh_ff, dsh_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              fits;

   // restoring division, one quotient bit per cycle, msb first
   assign fits = rem_ff >= dsh_ff;

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = CW'(dividend);
         dsh_in  = CW'(divisor) << (QUO_W - 1);
         quo_in  = '0;
         step_in = STEP_W'(QUO_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? rem_ff - dsh_ff : rem_ff;
         dsh_in  = dsh_ff >> 1;
         quo_in  = QUO_W'({quo_ff, fits});
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

### rtl/windowed_peak_strength_core.sv
`timescale 1ns / 1ps
// windowed peak strength scorer
// request channel: one sample per request, tlast marks the final frame of a
// sequence. result channel: one scored frame per result, trailing the input
// by W frames; the final request of a sequence releases all pending frames,
// the last of them with tlast high, then clears the sequence state.
// csr_wen/csr_wdata set W (window_half); write only while the block is idle.
// samples sit in a circular buffer in a single-port-read ram. scoring a frame
// reads its 2W+1 window entries, one per cycle; for a peak candidate it then
// divides the neighbor sum by 2W in a bit-serial divider of SW steps (SAMPLE_BITS, at most SAMPLE_W).
// a final request scores, in turn, each of the up to W + 1 frames it releases.
// one finished result is held in the output register; while the receiver
// stalls, the block accepts the next request and works up to the next result.
// reset is synchronous: the buffer is treated as empty through a fill count,
// so there is no clearing pass, and W returns to 8.

`include "windowed_peak_strength_core_macros.svh"

module windowed_peak_strength_core import wps_pkg::*; #(
   parameter int MAX_W       = 31,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [SAMPLE_W-1:0]   req_tdata,   // sample
   input  logic                  req_tlast,   // last_in
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // strength, frame_index, zero pad
   output logic                  rsp_tuser,   // is_peak
   output logic                  rsp_tlast,   // last_out
   input  logic                  csr_wen,
   input  logic [CFG_W-1:0]      csr_wdata    // window_half
);

   localparam int DEPTH   = 2 * MAX_W + 1;
   localparam int PTR_W   = $clog2(DEPTH);
   localparam int AGE_W   = PTR_W + 1;
   localparam int CNT_MAX = (DEPTH > FILL_CAP) ? DEPTH : FILL_CAP;
   localparam int CNT_W   = $clog2(CNT_MAX + 1);
   localparam int CMP_W   = (CNT_W > AGE_W) ? CNT_W : AGE_W;
   localparam int SW      = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
   localparam int SUM_W   = SW + $clog2(2 * MAX_W + 1);
   localparam int WIN_MAX = (MAX_W < (1 << CFG_W) - 1) ? MAX_W : (1 << CFG_W) - 1;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_START = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_TAIL  = 3'd3;
   localparam logic [2:0] ST_EVAL  = 3'd4;
   localparam logic [2:0] ST_DIV   = 3'd5;
   localparam logic [2:0] ST_OUT   = 3'd6;

   logic [2:0]              state_ff, state_in;
   logic [CFG_W-1:0]        csr_ff, csr_in;
   logic [PTR_W-1:0]        ptr_ff, ptr_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [INDEX_W-1:0]      emit_ff, emit_in;
   logic                    seq_last_ff, seq_last_in;
   logic [CFG_W-1:0]        d_ff, d_in;
   logic signed [AGE_W-1:0] age_ff, age_in;
   logic [SUM_W-1:0]        sum_ff, sum_in;
   logic [SW-1:0]           max_ff, max_in;
   logic [SW-1:0]           x_ff, x_in;
   logic                    tag_act_ff, tag_act_in;
   logic                    tag_ok_ff, tag_ok_in;
   logic                    tag_ctr_ff, tag_ctr_in;
   logic [STRENGTH_W-1:0]   res_str_ff, res_str_in;
   logic                    res_peak_ff, res_peak_in;
   logic                    rsp_tvalid_ff, rsp_tvalid_in;
   logic [STRENGTH_W-1:0]   out_str_ff, out_str_in;
   logic                    out_peak_ff, out_peak_in;
   logic [INDEX_W-1:0]      out_idx_ff, out_idx_in;
   logic                    out_last_ff, out_last_in;

   logic [CFG_W-1:0]        w_eff;
   logic                    accept;
   logic [CNT_W-1:0]        cnt_inc;
   logic [FILL_W-1:0]       fill_new, fill_dec;
   logic [PTR_W-1:0]        ptr_next;
   logic signed [AGE_W-1:0] d_age, w_age, age_lo;
   logic                    age_ok;
   logic signed [PTR_W+1:0] addr_diff;
   logic [PTR_W-1:0]        rd_addr;
   logic [SW-1:0]           rd_data, tap_val;
   logic                    rd_en;
   logic                    div_start;
   logic                    out_load;
   div_status_type          div_stat;
   logic [SW-1:0]           quotient;

   always_comb begin
      if (csr_ff == '0) begin
         w_eff = CFG_W'(1);
      end else if (int'(csr_ff) > WIN_MAX) begin
         w_eff = CFG_W'(WIN_MAX);
      end else begin
         w_eff = csr_ff;
      end
   end

   assign accept   = req_tvalid && req_tready;
   assign cnt_inc  = (cnt_ff == CNT_W'(CNT_MAX)) ? cnt_ff : cnt_ff + 1'b1;
   assign fill_new = (cnt_inc > CNT_W'(FILL_CAP)) ? FILL_W'(FILL_CAP) : FILL_W'(cnt_inc);
   assign fill_dec = fill_new - 1'b1;
   assign ptr_next = (ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : ptr_ff + 1'b1;

   // window ages run from d + w down to d - w; age 0 is the newest sample
   assign d_age  = AGE_W'(d_ff);
   assign w_age  = AGE_W'(w_eff);
   assign age_lo = d_age - w_age;
   assign age_ok = !age_ff[AGE_W-1] &&
                   (CMP_W'(age_ff[AGE_W-2:0]) < CMP_W'(cnt_ff));

   assign addr_diff = $signed({2'b00, ptr_ff}) - (PTR_W + 2)'(age_ff);
   assign rd_addr   = addr_diff[PTR_W+1] ? PTR_W'(addr_diff + (PTR_W + 2)'(DEPTH))
                                         : PTR_W'(addr_diff);
   assign rd_en     = (state_ff == ST_SCAN);
   assign tap_val   = tag_ok_ff ? rd_data : '0;

   wps_ram #(
      .WIDTH (SW),
      .DEPTH (DEPTH)
   ) u_line (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (ptr_next),
      .wr_data (req_tdata[SW-1:0]),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   wps_div #(
      .NUM_W (SUM_W),
      .QUO_W (SW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  ({w_eff, 1'b0}),
      .status   (div_stat),
      .quotient (quotient)
   );

   always_comb begin
      state_in      = state_ff;
      csr_in        = csr_wen ? csr_wdata : csr_ff;
      ptr_in        = ptr_ff;
      cnt_in        = cnt_ff;
      emit_in       = emit_ff;
      seq_last_in   = seq_last_ff;
      d_in          = d_ff;
      age_in        = age_ff;
      sum_in        = sum_ff;
      max_in        = max_ff;
      x_in          = x_ff;
      tag_act_in    = 1'b0;
      tag_ok_in     = age_ok;
      tag_ctr_in    = (age_ff == d_age);
      res_str_in    = res_str_ff;
      res_peak_in   = res_peak_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      out_str_in    = out_str_ff;
      out_peak_in   = out_peak_ff;
      out_idx_in    = out_idx_ff;
      out_last_in   = out_last_ff;
      div_start     = 1'b0;
      out_load      = 1'b0;

      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      // ram data for the address issued in the previous cycle
      if (tag_act_ff) begin
         if (tag_ctr_ff) begin
            x_in = tap_val;
         end else begin
            sum_in = sum_ff + SUM_W'(tap_val);
            max_in = (tap_val > max_ff) ? tap_val : max_ff;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ptr_in      = ptr_next;
               cnt_in      = cnt_inc;
               seq_last_in = req_tlast;
               if (req_tlast) begin
                  d_in     = (fill_dec < FILL_W'(w_eff)) ? CFG_W'(fill_dec) : w_eff;
                  state_in = ST_START;
               end else if (fill_new > FILL_W'(w_eff)) begin
                  d_in     = w_eff;
                  state_in = ST_START;
               end
            end
         end
         ST_START: begin
            age_in   = d_age + w_age;
            sum_in   = '0;
            max_in   = '0;
            x_in     = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            tag_act_in = 1'b1;
            age_in     = age_ff - 1'b1;
            if (age_ff == age_lo) begin
               state_in = ST_TAIL;
            end
         end
         ST_TAIL: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (x_ff != '0 && x_ff >= max_ff) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end else begin
               res_str_in  = '0;
               res_peak_in = 1'b0;
               state_in    = ST_OUT;
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               res_str_in  = STRENGTH_W'(x_ff - quotient);
               res_peak_in = (x_ff != quotient);
               state_in    = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               out_load      = 1'b1;
               rsp_tvalid_in = 1'b1;
               out_str_in    = res_str_ff;
               out_peak_in   = res_peak_ff;
               out_idx_in    = emit_ff;
               out_last_in   = seq_last_ff && (d_ff == '0);
               emit_in       = emit_ff + 1'b1;
               if (seq_last_ff && d_ff != '0) begin
                  d_in     = d_ff - 1'b1;
                  state_in = ST_START;
               end else begin
                  state_in = ST_IDLE;
                  if (seq_last_ff) begin
                     cnt_in  = '0;
                     emit_in = '0;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         csr_ff        <= CFG_W'(WINDOW_RESET);
         ptr_ff        <= '0;
         cnt_ff        <= '0;
         emit_ff       <= '0;
         tag_act_ff    <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         csr_ff        <= csr_in;
         ptr_ff        <= ptr_in;
         cnt_ff        <= cnt_in;
         emit_ff       <= emit_in;
         tag_act_ff    <= tag_act_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      seq_last_ff <= seq_last_in;
      d_ff        <= d_in;
      age_ff      <= age_in;
      sum_ff      <= sum_in;
      max_ff      <= max_in;
      x_ff        <= x_in;
      tag_ok_ff   <= tag_ok_in;
      tag_ctr_ff  <= tag_ctr_in;
      res_str_ff  <= res_str_in;
      res_peak_ff <= res_peak_in;
      out_str_ff  <= out_str_in;
      out_peak_ff <= out_peak_in;
      out_idx_ff  <= out_idx_in;
      out_last_ff <= out_last_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - STRENGTH_W - INDEX_W){1'b0}}, out_idx_ff, out_str_ff};
   assign rsp_tuser  = out_peak_ff;
   assign rsp_tlast  = out_last_ff;

   `WPS_ASSERT_IMP(a_peak_nonzero, clock, reset, rsp_tvalid_ff && out_peak_ff, out_str_ff != '0)
   `WPS_ASSERT_IMP(a_strength_sign, clock, reset, rsp_tvalid_ff, !out_str_ff[STRENGTH_W-1])
   `WPS_ASSERT_IMP(a_div_running, clock, reset, state_ff == ST_DIV, div_stat.busy || div_stat.done)
   `WPS_ASSERT_NEXT(a_last_clears, clock, reset, out_load && seq_last_ff && d_ff == '0, cnt_ff == '0 && emit_ff == '0)

endmodule

### tb/sv/peak_score_checker.sv
`timescale 1ns / 1ps

module peak_score_checker import wps_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [SAMPLE_W-1:0]   req_tdata,
   input  logic                  req_tlast,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  rsp_tuser,
   input  logic                  rsp_tlast,
   input  logic                  csr_wen,
   input  logic [CFG_W-1:0]      csr_wdata,
   output int                    fail_count,
   output int                    pending
);

   localparam int MAX_HALF = 31;
   localparam int DEPTH    = 2 * MAX_HALF + 1;

   typedef struct {
      logic [STRENGTH_W-1:0] strength;
      logic                  is_peak;
      logic [INDEX_W-1:0]    frame_index;
      logic                  last_out;
   } frame_score_type;

   frame_score_type     pending_scores[$];
   logic [SAMPLE_W-1:0] history[DEPTH];
   logic [CFG_W-1:0]    window_reg;
   int unsigned         fill;
   logic [INDEX_W-1:0]  next_index;
   int                  mismatch_count = 0;

   function automatic int unsigned history_at(int age);
      if (age < 0 || age >= DEPTH) return 0;
      return history[age];
   endfunction

   function automatic void score_frame(int age, int w, bit fin);
      int unsigned     x;
      int unsigned     peak_max;
      int unsigned     near_sum;
      int unsigned     pv;
      int unsigned     fv;
      int unsigned     den;
      frame_score_type e;
      x        = history_at(age);
      peak_max = 0;
      near_sum = 0;
      for (int k = 1; k <= w; k++) begin
         pv = history_at(age + k);
         fv = history_at(age - k);
         near_sum += pv + fv;
         if (pv > peak_max) peak_max = pv;
         if (fv > peak_max) peak_max = fv;
      end
      e.strength = '0;
      e.is_peak  = 1'b0;
      if (x > 0 && x >= peak_max) begin
         den        = 2 * w;
         e.strength = STRENGTH_W'(x - near_sum / den);
         e.is_peak  = (den * x > near_sum);
      end
      e.frame_index = next_index;
      e.last_out    = fin;
      next_index    = next_index + 1'b1;
      pending_scores.insert(pending_scores.size(), e);
   endfunction

   always @(posedge clock) begin
      frame_score_type e;
      int              w;
      int              d;
      if (reset) begin
         foreach (history[i]) history[i] = '0;
         window_reg = CFG_W'(WINDOW_RESET);
         fill       = 0;
         next_index = '0;
         pending_scores.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_scores.size() == 0) begin
               if (mismatch_count < 10)
                  $display("result with none expected: strength %h peak %b index %0d last %b",
                           rsp_tdata[STRENGTH_W-1:0], rsp_tuser,
                           rsp_tdata[STRENGTH_W +: INDEX_W], rsp_tlast);
               mismatch_count++;
            end else begin
               e = pending_scores.pop_front();
               if (rsp_tdata[STRENGTH_W-1:0] !== e.strength || rsp_tuser !== e.is_peak ||
                   rsp_tdata[STRENGTH_W +: INDEX_W] !== e.frame_index ||
                   rsp_tlast !== e.last_out) begin
                  if (mismatch_count < 10)
                     $display("frame %0d: expected strength %h peak %b index %0d last %b, got strength %h peak %b index %0d last %b",
                              e.frame_index, e.strength, e.is_peak, e.frame_index,
                              e.last_out, rsp_tdata[STRENGTH_W-1:0], rsp_tuser,
                              rsp_tdata[STRENGTH_W +: INDEX_W], rsp_tlast);
                  mismatch_count++;
               end
            end
         end

         if (req_tvalid && req_tready) begin
            w = (window_reg == 0) ? 1 : ((window_reg > MAX_HALF) ? MAX_HALF : int'(window_reg));
            for (int i = DEPTH - 1; i > 0; i--) history[i] = history[i-1];
            history[0] = req_tdata;
            if (fill < 63) fill++;
            if (!req_tlast) begin
               if (fill > w) score_frame(w, w, 1'b0);
            end else begin
               // final request releases every frame still waiting
               d = (int'(fill) - 1 < w) ? int'(fill) - 1 : w;
               for (; d >= 0; d--) score_frame(d, w, d == 0);
               foreach (history[i]) history[i] = '0;
               fill       = 0;
               next_index = '0;
            end
         end

         if (csr_wen) window_reg = csr_wdata;
      end
      fail_count <= mismatch_count;
      pending    <= pending_scores.size();
   end

endmodule

### tb/sv/windowed_peak_strength_core_tb.sv
`timescale 1ns / 1ps

module windowed_peak_strength_core_tb import wps_pkg::*;;

   localparam int STALL_LIMIT = 5000;
   localparam int SETTLE      = 100;
   localparam int SQUEEZE     = 300;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [SAMPLE_W-1:0]   req_tdata  = '0;
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_wen    = 1'b0;
   logic [CFG_W-1:0]      csr_wdata  = '0;

   int  fail_count;
   int  pending;
   bit  idle_on      = 1'b1;
   bit  squeeze_req  = 1'b0;
   bit  squeeze_done = 1'b0;
   int  squeeze_left = 0;
   int  rx_idle_left = 0;
   int  rx_busy_left = 0;
   int  quiet_cycles = 0;

   always #1 clock = ~clock;

   windowed_peak_strength_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   peak_score_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // result side: random stall bursts while idle_on is set, one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (squeeze_req && !squeeze_done) begin
         squeeze_done <= 1'b1;
         squeeze_left <= SQUEEZE;
         rsp_tready   <= 1'b0;
      end else if (squeeze_left != 0) begin
         squeeze_left <= squeeze_left - 1;
         rsp_tready   <= 1'b0;
      end else if (!idle_on) begin
         rsp_tready <= 1'b1;
      end else if (rx_idle_left != 0) begin
         rx_idle_left <= rx_idle_left - 1;
         rsp_tready   <= 1'b0;
      end else if (rx_busy_left != 0) begin
         rx_busy_left <= rx_busy_left - 1;
         rsp_tready   <= 1'b1;
      end else if ($urandom_range(0, 2) == 0) begin
         rx_idle_left <= $urandom_range(0, 14);
         rsp_tready   <= 1'b0;
      end else begin
         rx_busy_left <= $urandom_range(0, 30);
         rsp_tready   <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("windowed_peak_strength_core: mismatch");
            $finish;
         end
      end
   end

   task automatic send(input logic [SAMPLE_W-1:0] sample, input logic fin);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 15);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= sample;
      req_tlast  <= fin;
      do @(posedge clock); while (!req_tready);
   endtask

   // drain, let the block settle, then write W
   task automatic write_window(input logic [CFG_W-1:0] value);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen   <= 1'b0;
   endtask

   initial begin
      int                  w;
      int                  len;
      int                  sent;
      logic [CFG_W-1:0]    w_val;
      logic [SAMPLE_W-1:0] s;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset window, lone frame and short sequence
      send(16'hFFFF, 1'b1);
      send(16'h0000, 1'b0);
      send(16'h1234, 1'b0);
      send(16'h0000, 1'b1);

      // zero window reads as one: ties and a plateau
      write_window(5'd0);
      send(16'h0000, 1'b0);
      send(16'hFFFF, 1'b0);
      send(16'hFFFF, 1'b0);
      send(16'h0001, 1'b0);
      send(16'h0003, 1'b0);
      send(16'h0003, 1'b0);
      send(16'h0003, 1'b1);

      // widest window, sequence shorter than W
      write_window(5'd31);
      send(16'hFFFF, 1'b0);
      send(16'h8000, 1'b0);
      send(16'h0001, 1'b0);
      send(16'h7FFF, 1'b0);
      send(16'hFFFF, 1'b1);

      // window changed in the middle of a sequence
      write_window(5'd2);
      send(16'h0010, 1'b0);
      send(16'h0400, 1'b0);
      send(16'h0020, 1'b0);
      send(16'h0005, 1'b0);
      write_window(5'd5);
      send(16'h0900, 1'b0);
      send(16'h0001, 1'b0);
      send(16'h0000, 1'b0);
      send(16'h00FF, 1'b1);

      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0:       w_val = 5'd1;
            1:       w_val = 5'd31;
            default: w_val = CFG_W'($urandom_range(0, 31));
         endcase
         write_window(w_val);
         w = (w_val == 0) ? 1 : int'(w_val);
         if (phase == 0) squeeze_req <= 1'b1;
         if (phase == 4) idle_on <= 1'b0;
         sent = 0;
         while (sent < 12) begin
            if (phase == 3 && sent == 0)
               len = 70;
            else
               len = $urandom_range(1, w + 6);
            for (int i = 0; i < len; i++) begin
               case ($urandom_range(0, 9))
                  0, 1, 2, 3: s = SAMPLE_W'($urandom_range(0, 65535));
                  4, 5, 6:    s = SAMPLE_W'($urandom_range(0, 255));
                  7, 8:       s = '0;
                  default:    s = 16'hFFFF;
               endcase
               send(s, i == len - 1);
            end
            sent += len;
         end
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("windowed_peak_strength_core: match");
      else
         $display("windowed_peak_strength_core: mismatch");
      $finish;
   end

endmodule
